// File: rtl/dnsa_pkg.sv
// ----------------------------------------------------------------------------
// dnsa_pkg
// Shared constants and types for the DNS A-record extractor: status codes,
// header layout, and the result word passed to the output stage.
// ----------------------------------------------------------------------------
package dnsa_pkg;

  // Default packet size limit in bytes
  localparam int MAX_PACKET_DEF = 512;

  // Header layout
  localparam int HDR_LEN      = 12;
  localparam int ANCOUNT_HI   = 6;
  localparam int ANCOUNT_LO   = 7;

  // Answer fixed part: type, class, TTL, rdlength
  localparam logic [3:0] FIX_LEN = 4'd10;

  // Question tail after a zero byte, and after a pointer's first byte
  localparam logic [15:0] QTAIL_LEN     = 16'd4;
  localparam logic [15:0] QTAIL_PTR_LEN = 16'd5;

  // Compression pointer mark
  localparam logic [7:0] PTR_MASK = 8'hC0;

  // Result status codes
  localparam logic [2:0] ST_FOUND = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_NOANS = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_NOA   = 3'd4;

  // One result word
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ipv4_address;
  } dnsa_result_t;

endpackage

// File: rtl/dnsa_parser.sv
// ----------------------------------------------------------------------------
// dnsa_parser
// Per-byte parse state of the DNS response. Each accepted byte updates the
// registered state; on the last byte the outcome is formed from the updated
// state and the state returns to the header phase.
// ----------------------------------------------------------------------------
module dnsa_parser #(
  parameter int MAX_PACKET = dnsa_pkg::MAX_PACKET_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output dnsa_pkg::dnsa_result_t result
);
  import dnsa_pkg::*;

  localparam int OFS_W = $clog2(MAX_PACKET + 1);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QTAIL,
    PH_ANAME,
    PH_AFIX,
    PH_RDATA,
    PH_DONE
  } phase_t;

  phase_t           parse_phase, parse_phase_next;
  logic [OFS_W-1:0] byte_offset, byte_offset_next;
  logic [15:0]      skip_count, skip_count_next;
  logic [15:0]      answers_left, answers_left_next;
  logic [15:0]      record_type, record_type_next;
  logic [15:0]      record_class, record_class_next;
  logic [15:0]      rdata_length, rdata_length_next;
  logic [31:0]      address_capture, address_capture_next;
  logic [2:0]       final_status, final_status_next;

  logic             name_end;
  logic             name_ptr;
  logic [3:0]       fix_idx;
  logic [2:0]       out_status;

  // Name byte: label length, zero terminator or compression pointer
  assign name_end = (skip_count == 16'd0) &&
                    ((data_byte == 8'd0) || ((data_byte & PTR_MASK) == PTR_MASK));
  assign name_ptr = (data_byte & PTR_MASK) == PTR_MASK;
  assign fix_idx  = FIX_LEN - skip_count[3:0];

  // Next parse state for one byte
  always_comb begin
    parse_phase_next     = parse_phase;
    byte_offset_next     = byte_offset;
    skip_count_next      = skip_count;
    answers_left_next    = answers_left;
    record_type_next     = record_type;
    record_class_next    = record_class;
    rdata_length_next    = rdata_length;
    address_capture_next = address_capture;
    final_status_next    = final_status;

    if (byte_offset < OFS_W'(MAX_PACKET)) begin
      byte_offset_next = byte_offset + OFS_W'(1);
      unique case (parse_phase)
        PH_HEADER: begin
          if (byte_offset == OFS_W'(ANCOUNT_HI)) begin
            answers_left_next = {data_byte, 8'h00};
          end else if (byte_offset == OFS_W'(ANCOUNT_LO)) begin
            answers_left_next = {answers_left[15:8], data_byte};
          end
          if (byte_offset == OFS_W'(HDR_LEN - 1)) begin
            if (answers_left == 16'd0) begin
              parse_phase_next  = PH_DONE;
              final_status_next = ST_NOANS;
            end else begin
              parse_phase_next = PH_QNAME;
              skip_count_next  = 16'd0;
            end
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (skip_count != 16'd0) begin
            skip_count_next = skip_count - 16'd1;
          end else if (name_end) begin
            if (parse_phase == PH_QNAME) begin
              parse_phase_next = PH_QTAIL;
              skip_count_next  = name_ptr ? QTAIL_PTR_LEN : QTAIL_LEN;
            end else begin
              parse_phase_next = PH_AFIX;
              skip_count_next  = name_ptr ? 16'(FIX_LEN) + 16'd1 : 16'(FIX_LEN);
            end
          end else begin
            skip_count_next = {8'h00, data_byte};
          end
        end
        PH_QTAIL: begin
          skip_count_next = skip_count - 16'd1;
          if (skip_count == 16'd1) begin
            parse_phase_next = PH_ANAME;
          end
        end
        PH_AFIX: begin
          // Capture type, class and rdlength; skip the TTL
          if (skip_count <= 16'(FIX_LEN)) begin
            case (fix_idx)
              4'd0:    record_type_next  = {data_byte, 8'h00};
              4'd1:    record_type_next  = {record_type[15:8], data_byte};
              4'd2:    record_class_next = {data_byte, 8'h00};
              4'd3:    record_class_next = {record_class[15:8], data_byte};
              4'd8:    rdata_length_next = {data_byte, 8'h00};
              4'd9:    rdata_length_next = {rdata_length[15:8], data_byte};
              default: ;
            endcase
          end
          skip_count_next = skip_count - 16'd1;
          if (skip_count == 16'd1) begin
            if (rdata_length_next == 16'd0) begin
              answers_left_next = answers_left - 16'd1;
              if (answers_left == 16'd1) begin
                parse_phase_next  = PH_DONE;
                final_status_next = ST_NOA;
              end else begin
                parse_phase_next = PH_ANAME;
                skip_count_next  = 16'd0;
              end
            end else begin
              parse_phase_next     = PH_RDATA;
              skip_count_next      = rdata_length_next;
              address_capture_next = 32'd0;
            end
          end
        end
        PH_RDATA: begin
          address_capture_next = {address_capture[23:0], data_byte};
          skip_count_next      = skip_count - 16'd1;
          if (skip_count == 16'd1) begin
            if (record_type == 16'd1 && record_class == 16'd1 &&
                rdata_length == 16'd4) begin
              parse_phase_next  = PH_DONE;
              final_status_next = ST_FOUND;
            end else begin
              answers_left_next = answers_left - 16'd1;
              if (answers_left == 16'd1) begin
                parse_phase_next  = PH_DONE;
                final_status_next = ST_NOA;
              end else begin
                parse_phase_next = PH_ANAME;
                skip_count_next  = 16'd0;
              end
            end
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  // Outcome as seen after this byte
  always_comb begin
    if (parse_phase_next == PH_DONE) begin
      out_status = final_status_next;
    end else if (parse_phase_next == PH_HEADER) begin
      out_status = ST_SHORT;
    end else begin
      out_status = ST_TRUNC;
    end
  end

  assign result.status       = out_status;
  assign result.ipv4_address = (out_status == ST_FOUND) ? address_capture_next : 32'd0;

  // Hold parse state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      parse_phase     <= PH_HEADER;
      byte_offset     <= '0;
      skip_count      <= '0;
      answers_left    <= '0;
      record_type     <= '0;
      record_class    <= '0;
      rdata_length    <= '0;
      address_capture <= '0;
      final_status    <= ST_FOUND;
    end else if (take) begin
      parse_phase     <= parse_phase_next;
      byte_offset     <= byte_offset_next;
      skip_count      <= skip_count_next;
      answers_left    <= answers_left_next;
      record_type     <= record_type_next;
      record_class    <= record_class_next;
      rdata_length    <= rdata_length_next;
      address_capture <= address_capture_next;
      final_status    <= final_status_next;
    end
  end

endmodule

// File: rtl/dnsa_out_reg.sv
// ----------------------------------------------------------------------------
// dnsa_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module dnsa_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  dnsa_pkg::dnsa_result_t load_word,
  output logic                  slot_free,
  output logic                  result_valid,
  input  logic                  result_ready,
  output dnsa_pkg::dnsa_result_t result_word
);
  import dnsa_pkg::*;

  logic         word_valid;
  dnsa_result_t word;

  // Slot opens when empty or when the held word leaves this cycle
  assign slot_free    = !word_valid || result_ready;
  assign result_valid = word_valid;
  assign result_word  = word;

  // Control: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (load) begin
      word_valid <= 1'b1;
    end else if (result_ready) begin
      word_valid <= 1'b0;
    end
  end

  // Payload: load a new word
  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end
  end

endmodule

// File: rtl/dns_a_record_extractor.sv
// ----------------------------------------------------------------------------
// dns_a_record_extractor
// Takes a DNS response one byte per cycle and reports the first A record.
// ----------------------------------------------------------------------------
// Accepts one response byte every cycle; each byte updates the parse state in
// the cycle it is taken. On the byte marked last, one result (status and IPv4
// address) appears on the result channel in the following cycle and is held
// in a single output register until taken. Bytes without the last mark are
// taken even while a result waits; data_ready drops only when a last byte
// arrives while the previous result is still unread. Bytes beyond MAX_PACKET
// are dropped, but their last mark still produces a result.
module dns_a_record_extractor #(
  parameter int MAX_PACKET = dnsa_pkg::MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic [31:0] ipv4_address
);
  import dnsa_pkg::*;

  logic         take;
  logic         slot_free;
  dnsa_result_t parse_result;
  dnsa_result_t held_result;

  // Take a byte unless it ends a packet and the result slot is busy
  assign data_ready = slot_free || !last_byte;
  assign take       = data_valid && data_ready;

  dnsa_parser #(
    .MAX_PACKET(MAX_PACKET)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .result    (parse_result)
  );

  dnsa_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (take && last_byte),
    .load_word    (parse_result),
    .slot_free    (slot_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (held_result)
  );

  assign status       = held_result.status;
  assign ipv4_address = held_result.ipv4_address;

`ifndef NO_ASSERTIONS
  // A packet end always produces a result next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    data_valid && data_ready && last_byte |=> result_valid)
    else $error("no result after last byte");

  // Stall only for a last byte meeting an unread result
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !data_ready |-> result_valid && !result_ready && last_byte)
    else $error("input stalled without cause");

  // Address is zero unless a record was found
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_FOUND |-> ipv4_address == 32'd0)
    else $error("address set on a failed lookup");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status <= ST_NOA)
    else $error("undefined status code");
`endif

endmodule
